FILE: design/tmwf_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the trimmed-mean window filter.
// No dependencies; every other design file uses this package.
package tmwf_pkg;

    // Fixed sample width of every channel
    localparam int SAMPLE_W = 24;

    // Default window length per channel
    localparam int WINDOW_LEN_DEF = 50;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    // Largest and smallest sample values, used to seed the min/max scan
    localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    // One request: a new sample for each of the four channels
    typedef struct packed {
        sample_t sample_a;
        sample_t sample_b;
        sample_t sample_c;
        sample_t sample_d;
    } tmwf_in_t;

    // One result: the trimmed mean of each channel's window
    typedef struct packed {
        sample_t filtered_a;
        sample_t filtered_b;
        sample_t filtered_c;
        sample_t filtered_d;
    } tmwf_out_t;

    // Controls from the sequencer to the per-channel accumulators
    typedef struct packed {
        logic clear;
        logic scan;
        logic trim;
    } acc_ctl_t;

endpackage

FILE: design/tmwf_cell.sv
`timescale 1ns / 1ps
// One window cell: holds one sample of every channel and passes it on.
// Depends on tmwf_pkg for the sample bundle type.
module tmwf_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               shift,
    input  tmwf_pkg::tmwf_in_t din,
    output tmwf_pkg::tmwf_in_t dout
);

    tmwf_pkg::tmwf_in_t data_reg;

    // Windows start out full of zeros
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else if (shift)
        begin
            data_reg <= din;
        end
    end

    assign dout = data_reg;

endmodule

FILE: design/tmwf_acc.sv
`timescale 1ns / 1ps
// Per-channel accumulator: running sum, minimum and maximum over a scan,
// then the trimmed sum. Depends on tmwf_pkg.
module tmwf_acc #(
    parameter int SUM_W = 30
) (
    input  logic                    clk,
    input  tmwf_pkg::acc_ctl_t      ctl,
    input  tmwf_pkg::sample_t       sample,
    output logic signed [SUM_W-1:0] trim
);

    import tmwf_pkg::*;

    logic signed [SUM_W-1:0] sum_reg;
    sample_t                 lo_reg;
    sample_t                 hi_reg;
    logic signed [SUM_W-1:0] trim_reg;

    // Scan one sample per cycle; trimmed sum drops one min and one max
    always_ff @(posedge clk)
    begin
        if (ctl.clear)
        begin
            sum_reg <= '0;
            lo_reg  <= SAMPLE_MAX;
            hi_reg  <= SAMPLE_MIN;
        end
        else if (ctl.scan)
        begin
            sum_reg <= sum_reg + SUM_W'(sample);
            if (sample < lo_reg)
            begin
                lo_reg <= sample;
            end
            if (sample > hi_reg)
            begin
                hi_reg <= sample;
            end
        end
        if (ctl.trim)
        begin
            trim_reg <= sum_reg - SUM_W'(lo_reg) - SUM_W'(hi_reg);
        end
    end

    assign trim = trim_reg;

endmodule

FILE: design/tmwf_div.sv
`timescale 1ns / 1ps
// Signed division by a constant through reciprocal multiplication,
// truncating toward zero. Depends on tmwf_pkg.
module tmwf_div #(
    parameter int SUM_W   = 30,
    parameter int DIVISOR = 48
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [SUM_W-1:0] dividend,
    output logic                    busy,
    output logic                    done,
    output tmwf_pkg::sample_t       quotient
);

    import tmwf_pkg::*;

    // The dividend magnitude stays below 2^(SUM_W-1)
    localparam int MAG_W  = SUM_W - 1;
    localparam int REC_W  = MAG_W + 1;
    localparam int PROD_W = MAG_W + REC_W;
    localparam int SHIFT  = MAG_W + $clog2(DIVISOR);

    // ceil(2^SHIFT / DIVISOR): floor of the scaled product is the exact quotient
    localparam logic [63:0] RECIP_WIDE =
        ((64'd1 << SHIFT) + 64'(DIVISOR - 1)) / 64'(DIVISOR);
    localparam logic [REC_W-1:0] RECIP = RECIP_WIDE[REC_W-1:0];

    logic              mul_reg;
    logic              done_reg;
    logic              neg_reg;
    logic [MAG_W-1:0]  mag_reg;
    logic [PROD_W-1:0] prod_reg;

    sample_t           q_mag;

    // Control: operand load on start, then the multiply, then done
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            mul_reg  <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (mul_reg)
        begin
            mul_reg  <= 1'b0;
            done_reg <= 1'b1;
        end
    end

    // Datapath: magnitude and sign on start, MAG_W x REC_W product after
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[SUM_W-1];
            mag_reg <= dividend[SUM_W-1] ? MAG_W'(-dividend) : MAG_W'(dividend);
        end
        if (mul_reg)
        begin
            prod_reg <= PROD_W'(mag_reg) * PROD_W'(RECIP);
        end
    end

    // The trimmed mean lies inside the sample range, so 24 bits suffice
    assign q_mag    = prod_reg[SHIFT +: SAMPLE_W];
    assign quotient = neg_reg ? SAMPLE_W'(-q_mag) : q_mag;
    assign busy     = mul_reg;
    assign done     = done_reg;

    // A start never lands in the middle of a division
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy)
        else $error("divider restarted while busy");

    // Done comes exactly after the multiply cycle
    a_done_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done) |-> $past(busy))
        else $error("divider done without multiply");

    // Done rises in the cycle after the multiply
    a_mul_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done)
        else $error("divider multiply did not finish");

endmodule

FILE: design/trimmed_mean_window_filter_core.sv
`timescale 1ns / 1ps
// Top level of the four-channel sliding-window trimmed-mean filter.
// Depends on tmwf_pkg, tmwf_cell, tmwf_acc and tmwf_div.
//
//   Channel   Valid          Stall          Payload
//   input     sample_valid   sample_stall   samples  (tmwf_in_t)
//   output    filt_valid     filt_stall     filtered (tmwf_out_t)
//
// A request shifts into a chain of WINDOW_LEN cells; the chain then rotates
// once around while an accumulator per channel scans sum, min and max.
// The trimmed sum is registered next, then the reciprocal divider per
// channel registers operand and product, and the result register loads.
// The next request is taken only once the result has been loaded and the
// sequencer is back in idle, so requests do not overlap.
// Reset clears the windows to zeros and the slot position to the start.
// A waiting result does not block the next request; a result stalls in
// place only if the previous one has still not been taken.
module trimmed_mean_window_filter_core #(
    parameter int WINDOW_LEN = tmwf_pkg::WINDOW_LEN_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sample_valid,
    output logic                sample_stall,
    input  tmwf_pkg::tmwf_in_t  samples,
    output logic                filt_valid,
    input  logic                filt_stall,
    output tmwf_pkg::tmwf_out_t filtered
);

    import tmwf_pkg::*;

    localparam int SUM_W   = SAMPLE_W + $clog2(WINDOW_LEN);
    localparam int DIVISOR = WINDOW_LEN - 2;
    localparam int CNT_W   = $clog2(WINDOW_LEN);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_TRIM,
        ST_START,
        ST_WAIT
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] scan_cnt_reg;
    logic             filt_valid_reg;
    tmwf_out_t        filtered_reg;

    logic             accept;
    logic             shift;
    logic             out_free;
    logic             res_load;
    logic             div_start;
    acc_ctl_t         acc_ctl;
    tmwf_in_t         cell_q [WINDOW_LEN];
    tmwf_in_t         chain_in;

    logic signed [SUM_W-1:0] trim_a, trim_b, trim_c, trim_d;
    sample_t          quo_a, quo_b, quo_c, quo_d;
    logic [3:0]       div_busy;
    logic [3:0]       div_done;

    // Handshake and sequencing controls
    assign accept       = sample_valid && !sample_stall;
    assign sample_stall = (state_reg != ST_IDLE);
    assign out_free     = !filt_valid_reg || !filt_stall;
    assign res_load     = (state_reg == ST_WAIT) && (&div_done) && out_free;
    assign shift        = accept || (state_reg == ST_SCAN);
    assign div_start    = (state_reg == ST_START);
    assign acc_ctl      = '{clear: accept,
                            scan:  (state_reg == ST_SCAN),
                            trim:  (state_reg == ST_TRIM)};

    // New request enters the head; during the scan the tail wraps around
    assign chain_in = (state_reg == ST_SCAN) ? cell_q[WINDOW_LEN-1] : samples;

    // Window chain
    genvar gi;
    generate
        for (gi = 0; gi < WINDOW_LEN; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                tmwf_cell u_cell (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .shift (shift),
                    .din   (chain_in),
                    .dout  (cell_q[gi])
                );
            end
            else
            begin : g_body
                tmwf_cell u_cell (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .shift (shift),
                    .din   (cell_q[gi-1]),
                    .dout  (cell_q[gi])
                );
            end
        end
    endgenerate

    // Per-channel accumulators fed from the chain tail
    tmwf_acc #(.SUM_W(SUM_W)) u_acc_a (
        .clk(clk), .ctl(acc_ctl), .sample(cell_q[WINDOW_LEN-1].sample_a), .trim(trim_a));
    tmwf_acc #(.SUM_W(SUM_W)) u_acc_b (
        .clk(clk), .ctl(acc_ctl), .sample(cell_q[WINDOW_LEN-1].sample_b), .trim(trim_b));
    tmwf_acc #(.SUM_W(SUM_W)) u_acc_c (
        .clk(clk), .ctl(acc_ctl), .sample(cell_q[WINDOW_LEN-1].sample_c), .trim(trim_c));
    tmwf_acc #(.SUM_W(SUM_W)) u_acc_d (
        .clk(clk), .ctl(acc_ctl), .sample(cell_q[WINDOW_LEN-1].sample_d), .trim(trim_d));

    // Per-channel dividers by WINDOW_LEN - 2
    tmwf_div #(.SUM_W(SUM_W), .DIVISOR(DIVISOR)) u_div_a (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(trim_a),
        .busy(div_busy[0]), .done(div_done[0]), .quotient(quo_a));
    tmwf_div #(.SUM_W(SUM_W), .DIVISOR(DIVISOR)) u_div_b (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(trim_b),
        .busy(div_busy[1]), .done(div_done[1]), .quotient(quo_b));
    tmwf_div #(.SUM_W(SUM_W), .DIVISOR(DIVISOR)) u_div_c (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(trim_c),
        .busy(div_busy[2]), .done(div_done[2]), .quotient(quo_c));
    tmwf_div #(.SUM_W(SUM_W), .DIVISOR(DIVISOR)) u_div_d (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(trim_d),
        .busy(div_busy[3]), .done(div_done[3]), .quotient(quo_d));

    // Sequencer, scan counter and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            scan_cnt_reg   <= '0;
            filt_valid_reg <= 1'b0;
            filtered_reg   <= '0;
        end
        else
        begin
            if (res_load)
            begin
                filt_valid_reg <= 1'b1;
                filtered_reg   <= '{filtered_a: quo_a, filtered_b: quo_b,
                                    filtered_c: quo_c, filtered_d: quo_d};
            end
            else if (filt_valid_reg && !filt_stall)
            begin
                filt_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    scan_cnt_reg <= '0;
                    if (accept)
                    begin
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    scan_cnt_reg <= scan_cnt_reg + 1'b1;
                    if (scan_cnt_reg == CNT_W'(WINDOW_LEN - 1))
                    begin
                        state_reg <= ST_TRIM;
                    end
                end
                ST_TRIM:
                begin
                    state_reg <= ST_START;
                end
                ST_START:
                begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT:
                begin
                    if (res_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign filt_valid = filt_valid_reg;
    assign filtered   = filtered_reg;

    // A request always starts a full scan
    a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_SCAN) && (scan_cnt_reg == '0))
        else $error("request did not start a scan");

    // The scan counter never passes the window length
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (scan_cnt_reg <= CNT_W'(WINDOW_LEN - 1)))
        else $error("scan counter out of range");

    // A new result is only loaded after all dividers finished
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(filt_valid) |-> $past((state_reg == ST_WAIT) && (&div_done)))
        else $error("result loaded without finished division");

    // Dividers run in lockstep
    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        ((div_busy == 4'b0000) || (div_busy == 4'b1111)) &&
        ((div_done == 4'b0000) || (div_done == 4'b1111)))
        else $error("dividers out of step");

endmodule
